>>> rtl/core/twrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twrs_pkg;

  localparam int WINDOW_DEPTH = 256;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int DIST_W       = 16;
  localparam int TIME_W       = 32;
  localparam int SUM_W        = 24;
  localparam int SQ_W         = 40;
  localparam int STAT_W       = 20;
  localparam int DVD_W        = 56;
  localparam int DVS_W        = 16;
  localparam int ROOT_W       = DVD_W / 2;
  localparam int REM_W        = ROOT_W + 3;
  localparam int STEP_W       = 6;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    REG_CEILING = 2'd0,
    REG_FLOOR   = 2'd1,
    REG_SPAN    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic              op;
    logic [DIST_W-1:0] dist_cm;
    logic [TIME_W-1:0] ts;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] ceiling;
    logic [DIST_W-1:0] floor_v;
    logic [TIME_W-1:0] span;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic              is_root;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } ds_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DVD_W-1:0]  result;
  } ds_stat_t;

  typedef struct packed {
    logic              accepted;
    logic [CNT_W-1:0]  count;
    logic [DIST_W-1:0] max_cm;
    logic [STAT_W-1:0] mean;
    logic [STAT_W-1:0] sd;
    logic              sd_valid;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DROP_RD, S_DROP, S_WRITE, S_MQ_RD, S_MQ_IDX, S_MQ_CMP, S_MQ_PUSH,
    S_EVICT, S_MAX_RD, S_MAX_IDX, S_MAX_GET, S_PROD, S_MEAN_GO, S_MEAN_WAIT,
    S_SD_GO, S_SD_WAIT, S_ROOT_GO, S_ROOT_WAIT, S_OUT
  } eng_state_t;

endpackage

`default_nettype wire

>>> rtl/core/time_window_range_stats.sv
// Per item: with two or more samples in the window the result needs the mean, the
// variance quotient and its root; with one sample only the mean; when empty, neither.
// Each popped max-queue entry and each evicted sample adds to the time per item.
// One item at a time; the shared unit runs the 56-step divide up to twice and the
// 28-step root at most once. A 2-beat input queue and the result register keep both
// sides moving. Reset (synchronous): window empty, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none

module time_window_range_stats (
  input  wire                                clk,
  input  wire                                rst,
  // configuration port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [twrs_pkg::ADDR_W-1:0]        paddr,
  input  wire  [twrs_pkg::DATA_W-1:0]        pwdata,
  output logic [twrs_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  // input channel
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                op,
  input  wire  [twrs_pkg::DIST_W-1:0]        distance_cm,
  input  wire  [twrs_pkg::TIME_W-1:0]        timestamp_ms,
  // result channel
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               accepted,
  output logic [twrs_pkg::CNT_W-1:0]         window_count,
  output logic [twrs_pkg::DIST_W-1:0]        window_max_cm,
  output logic [twrs_pkg::STAT_W-1:0]        mean_sixteenths,
  output logic [twrs_pkg::STAT_W-1:0]        stddev_sixteenths,
  output logic                               stddev_valid
);

  twrs_pkg::cfg_t     cfg;
  twrs_pkg::item_t    in_item;
  twrs_pkg::item_t    q_item;
  twrs_pkg::ds_cmd_t  ds_cmd;
  twrs_pkg::ds_stat_t ds_stat;
  twrs_pkg::result_t  res;
  twrs_pkg::reg_idx_t reg_sel;
  logic               q_valid;
  logic               q_pop;
  logic               cfg_write;

  // Register file: ceiling, floor and span at byte offsets 0, 4, 8.
  assign pready    = 1'b1;
  assign reg_sel   = twrs_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ceiling <= twrs_pkg::DIST_W'(2000);
      cfg.floor_v <= twrs_pkg::DIST_W'(500);
      cfg.span    <= twrs_pkg::TIME_W'(4000);
    end else if (cfg_write) begin
      unique case (reg_sel)
        twrs_pkg::REG_CEILING: cfg.ceiling <= pwdata[twrs_pkg::DIST_W-1:0];
        twrs_pkg::REG_FLOOR:   cfg.floor_v <= pwdata[twrs_pkg::DIST_W-1:0];
        twrs_pkg::REG_SPAN:    cfg.span    <= pwdata[twrs_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back; unmapped offsets return zero.
  always_comb begin
    unique case (reg_sel)
      twrs_pkg::REG_CEILING: prdata = twrs_pkg::DATA_W'(cfg.ceiling);
      twrs_pkg::REG_FLOOR:   prdata = twrs_pkg::DATA_W'(cfg.floor_v);
      twrs_pkg::REG_SPAN:    prdata = cfg.span;
      default:               prdata = '0;
    endcase
  end

  assign in_item.op      = op;
  assign in_item.dist_cm = distance_cm;
  assign in_item.ts      = timestamp_ms;

  // Front: hold up to two input beats; the source is stalled only while both are full.
  twrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Back: ring buffers, max queue, running sums and the result register.
  twrs_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .ds_cmd    (ds_cmd),
    .ds_stat   (ds_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Shared divider / square root: mean, variance quotient, then its root.
  twrs_divsqrt u_divsqrt (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ds_cmd),
    .stat (ds_stat)
  );

  assign accepted          = res.accepted;
  assign window_count      = res.count;
  assign window_max_cm     = res.max_cm;
  assign mean_sixteenths   = res.mean;
  assign stddev_sixteenths = res.sd;
  assign stddev_valid      = res.sd_valid;

  // Deviation flag follows the sample count.
  a_sd_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stddev_valid == (window_count >= twrs_pkg::CNT_W'(2))))
    else $error("stddev_valid disagrees with window_count");

  // Empty window reports zero statistics.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_count == '0 |->
      window_max_cm == '0 && mean_sixteenths == '0 && stddev_sixteenths == '0)
    else $error("empty window reported nonzero statistics");

  // Nonempty window maximum never sits below the floor.
  a_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_count != '0 |-> window_max_cm >= cfg.floor_v)
    else $error("window maximum below floor");

  // Window never exceeds its depth.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_count <= twrs_pkg::CNT_W'(twrs_pkg::WINDOW_DEPTH))
    else $error("window count beyond depth");

endmodule

`default_nettype wire

>>> rtl/core/twrs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module twrs_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire twrs_pkg::item_t in_item,
  output logic                 q_valid,
  output twrs_pkg::item_t      q_item,
  input  wire                  q_pop
);

  twrs_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            push;
  logic            pop;

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/twrs_divsqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module twrs_divsqrt (
  input  wire                    clk,
  input  wire                    rst,
  input  wire twrs_pkg::ds_cmd_t cmd,
  output twrs_pkg::ds_stat_t     stat
);

  localparam int DIV_STEPS  = twrs_pkg::DVD_W;
  localparam int ROOT_STEPS = twrs_pkg::ROOT_W;

  logic                         busy;
  logic                         done;
  logic                         root_mode;
  logic [twrs_pkg::STEP_W-1:0]  steps;
  logic [twrs_pkg::DVD_W-1:0]   acc;
  logic [twrs_pkg::DVD_W-1:0]   quo;
  logic [twrs_pkg::REM_W-1:0]   rem;
  logic [twrs_pkg::DVS_W-1:0]   divisor;

  logic [twrs_pkg::DVS_W:0]     div_sh;
  logic [twrs_pkg::REM_W-1:0]   root_sh;
  logic [twrs_pkg::REM_W-1:0]   trial;

  assign div_sh  = {rem[twrs_pkg::DVS_W-1:0], acc[twrs_pkg::DVD_W-1]};
  assign root_sh = {rem[twrs_pkg::REM_W-3:0], acc[twrs_pkg::DVD_W-1 -: 2]};
  assign trial   = {1'b0, quo[twrs_pkg::ROOT_W-1:0], 2'b01};

  assign stat.busy   = busy;
  assign stat.done   = done;
  assign stat.result = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && steps == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      root_mode <= cmd.is_root;
      steps     <= cmd.is_root ? twrs_pkg::STEP_W'(ROOT_STEPS - 1)
                               : twrs_pkg::STEP_W'(DIV_STEPS - 1);
      acc       <= cmd.dividend;
      divisor   <= cmd.divisor;
      quo       <= '0;
      rem       <= '0;
    end else if (busy) begin
      steps <= steps - twrs_pkg::STEP_W'(1);
      if (root_mode) begin
        acc <= acc << 2;
        if (root_sh >= trial) begin
          rem <= root_sh - trial;
          quo <= {quo[twrs_pkg::DVD_W-2:0], 1'b1};
        end else begin
          rem <= root_sh;
          quo <= {quo[twrs_pkg::DVD_W-2:0], 1'b0};
        end
      end else begin
        acc <= acc << 1;
        if (div_sh >= {1'b0, divisor}) begin
          rem <= twrs_pkg::REM_W'(div_sh - {1'b0, divisor});
          quo <= {quo[twrs_pkg::DVD_W-2:0], 1'b1};
        end else begin
          rem <= twrs_pkg::REM_W'(div_sh);
          quo <= {quo[twrs_pkg::DVD_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/twrs_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module twrs_engine (
  input  wire                     clk,
  input  wire                     rst,
  input  wire twrs_pkg::cfg_t     cfg,
  input  wire                     q_valid,
  input  wire twrs_pkg::item_t    q_item,
  output logic                    q_pop,
  output twrs_pkg::ds_cmd_t       ds_cmd,
  input  wire twrs_pkg::ds_stat_t ds_stat,
  output logic                    out_valid,
  input  wire                     out_stall,
  output twrs_pkg::result_t       res
);

  localparam int IW = twrs_pkg::IDX_W;
  localparam int CW = twrs_pkg::CNT_W;
  localparam int PW = CW + twrs_pkg::SQ_W;

  function automatic logic [IW-1:0] idx_add(input logic [IW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW+1-IW){1'b0}}, base} + {1'b0, off};
    if (s >= (CW+1)'(twrs_pkg::WINDOW_DEPTH)) begin
      s = s - (CW+1)'(twrs_pkg::WINDOW_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  logic [twrs_pkg::DIST_W-1:0] sample_mem [twrs_pkg::WINDOW_DEPTH];
  logic [twrs_pkg::TIME_W-1:0] time_mem   [twrs_pkg::WINDOW_DEPTH];
  logic [IW-1:0]               mq_mem     [twrs_pkg::WINDOW_DEPTH];

  twrs_pkg::eng_state_t state, state_next;

  twrs_pkg::item_t             cur;
  logic                        acc_flag;
  logic                        evicting;
  logic [IW-1:0]               oldest;
  logic [CW-1:0]               count;
  logic [twrs_pkg::SUM_W-1:0]  sum;
  logic [twrs_pkg::SQ_W-1:0]   sq;
  logic [IW-1:0]               mq_head;
  logic [CW-1:0]               mq_len;
  logic [twrs_pkg::TIME_W-1:0] newest;
  logic [IW-1:0]               slot_r;
  logic [twrs_pkg::DIST_W-1:0] max_r;
  logic [twrs_pkg::STAT_W-1:0] mean_r;
  logic [twrs_pkg::STAT_W-1:0] sd_r;
  logic [PW-1:0]               prod_s2;
  logic [2*twrs_pkg::SUM_W-1:0] prod_s1;
  logic [twrs_pkg::DVS_W-1:0]  den;
  logic [twrs_pkg::DVS_W-1:0]  den_next;
  logic [twrs_pkg::DVD_W-1:0]  quot_r;

  logic [twrs_pkg::DIST_W-1:0] samp_q;
  logic [twrs_pkg::TIME_W-1:0] time_q;
  logic [IW-1:0]               mq_q;

  logic [IW-1:0]               samp_addr;
  logic [IW-1:0]               mq_addr;
  logic                        ring_we;
  logic [IW-1:0]               slot;
  logic                        mq_we;
  logic [IW-1:0]               mq_waddr;

  logic                        reject;
  logic                        do_drop;
  logic                        mq_pop_ok;
  logic                        out_load;
  logic [PW-1:0]               num;
  logic [twrs_pkg::DIST_W-1:0] clamp;
  logic [twrs_pkg::ROOT_W-1:0] root;
  logic [2*twrs_pkg::DIST_W-1:0] drop_sq;
  logic [2*twrs_pkg::DIST_W-1:0] add_sq;

  assign reject    = (count != '0) && (q_item.ts <= newest);
  assign do_drop   = !evicting ||
                     (({1'b0, time_q} + {1'b0, cfg.span}) < {1'b0, cur.ts});
  assign mq_pop_ok = (samp_q <= cur.dist_cm);
  assign slot      = idx_add(oldest, count);
  assign out_load  = (state == twrs_pkg::S_OUT) && (!out_valid || !out_stall);
  assign num       = prod_s2 - PW'(prod_s1);
  assign root      = ds_stat.result[twrs_pkg::ROOT_W-1:0];
  assign drop_sq   = {{twrs_pkg::DIST_W{1'b0}}, samp_q} * {{twrs_pkg::DIST_W{1'b0}}, samp_q};
  assign add_sq    = {{twrs_pkg::DIST_W{1'b0}}, cur.dist_cm}
                     * {{twrs_pkg::DIST_W{1'b0}}, cur.dist_cm};
  assign den_next  = twrs_pkg::DVS_W'(count)
                     * (twrs_pkg::DVS_W'(count) - twrs_pkg::DVS_W'(1));

  always_comb begin
    clamp = (samp_q > cfg.ceiling) ? cfg.ceiling : samp_q;
    if (clamp < cfg.floor_v) clamp = cfg.floor_v;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      twrs_pkg::S_IDLE: begin
        if (q_valid) begin
          if (q_item.op == twrs_pkg::OP_CLEAR || reject) begin
            state_next = twrs_pkg::S_MAX_RD;
          end else if (count == CW'(twrs_pkg::WINDOW_DEPTH)) begin
            state_next = twrs_pkg::S_DROP_RD;
          end else begin
            state_next = twrs_pkg::S_WRITE;
          end
        end
      end
      twrs_pkg::S_DROP_RD: state_next = twrs_pkg::S_DROP;
      twrs_pkg::S_DROP: begin
        if (!evicting)    state_next = twrs_pkg::S_WRITE;
        else if (do_drop) state_next = twrs_pkg::S_EVICT;
        else              state_next = twrs_pkg::S_MAX_RD;
      end
      twrs_pkg::S_WRITE: state_next = twrs_pkg::S_MQ_RD;
      twrs_pkg::S_MQ_RD: begin
        state_next = (mq_len == '0) ? twrs_pkg::S_MQ_PUSH : twrs_pkg::S_MQ_IDX;
      end
      twrs_pkg::S_MQ_IDX: state_next = twrs_pkg::S_MQ_CMP;
      twrs_pkg::S_MQ_CMP: begin
        state_next = mq_pop_ok ? twrs_pkg::S_MQ_RD : twrs_pkg::S_MQ_PUSH;
      end
      twrs_pkg::S_MQ_PUSH: state_next = twrs_pkg::S_EVICT;
      twrs_pkg::S_EVICT: begin
        state_next = (count > CW'(1)) ? twrs_pkg::S_DROP_RD : twrs_pkg::S_MAX_RD;
      end
      twrs_pkg::S_MAX_RD:  state_next = twrs_pkg::S_MAX_IDX;
      twrs_pkg::S_MAX_IDX: state_next = twrs_pkg::S_MAX_GET;
      twrs_pkg::S_MAX_GET: state_next = twrs_pkg::S_PROD;
      twrs_pkg::S_PROD: begin
        state_next = (count == '0) ? twrs_pkg::S_OUT : twrs_pkg::S_MEAN_GO;
      end
      twrs_pkg::S_MEAN_GO: state_next = twrs_pkg::S_MEAN_WAIT;
      twrs_pkg::S_MEAN_WAIT: begin
        if (ds_stat.done) begin
          state_next = (count >= CW'(2)) ? twrs_pkg::S_SD_GO : twrs_pkg::S_OUT;
        end
      end
      twrs_pkg::S_SD_GO: state_next = twrs_pkg::S_SD_WAIT;
      twrs_pkg::S_SD_WAIT: begin
        if (ds_stat.done) state_next = twrs_pkg::S_ROOT_GO;
      end
      twrs_pkg::S_ROOT_GO: state_next = twrs_pkg::S_ROOT_WAIT;
      twrs_pkg::S_ROOT_WAIT: begin
        if (ds_stat.done) state_next = twrs_pkg::S_OUT;
      end
      twrs_pkg::S_OUT: begin
        if (out_load) state_next = twrs_pkg::S_IDLE;
      end
      default: state_next = twrs_pkg::S_IDLE;
    endcase
  end

  // outputs: memory ports, queue pop, unit commands
  always_comb begin
    q_pop       = 1'b0;
    samp_addr   = oldest;
    mq_addr     = mq_head;
    ring_we     = 1'b0;
    mq_we       = 1'b0;
    mq_waddr    = idx_add(mq_head, mq_len);
    ds_cmd      = '0;
    unique case (state)
      twrs_pkg::S_IDLE:    q_pop = q_valid;
      twrs_pkg::S_WRITE:   ring_we = 1'b1;
      twrs_pkg::S_MQ_RD:   mq_addr = idx_add(mq_head, mq_len - CW'(1));
      twrs_pkg::S_MQ_IDX:  samp_addr = mq_q;
      twrs_pkg::S_MQ_PUSH: mq_we = 1'b1;
      twrs_pkg::S_MAX_IDX: samp_addr = mq_q;
      twrs_pkg::S_MEAN_GO: begin
        ds_cmd.start    = 1'b1;
        ds_cmd.dividend = twrs_pkg::DVD_W'({sum, 4'b0000});
        ds_cmd.divisor  = twrs_pkg::DVS_W'(count);
      end
      twrs_pkg::S_SD_GO: begin
        ds_cmd.start    = 1'b1;
        ds_cmd.dividend = {num[twrs_pkg::DVD_W-9:0], 8'h00};
        ds_cmd.divisor  = den;
      end
      twrs_pkg::S_ROOT_GO: begin
        ds_cmd.start    = 1'b1;
        ds_cmd.is_root  = 1'b1;
        ds_cmd.dividend = quot_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    samp_q <= sample_mem[samp_addr];
    time_q <= time_mem[oldest];
    mq_q   <= mq_mem[mq_addr];
    if (ring_we) begin
      sample_mem[slot] <= cur.dist_cm;
      time_mem[slot]   <= cur.ts;
    end
    if (mq_we) begin
      mq_mem[mq_waddr] <= slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= twrs_pkg::S_IDLE;
      oldest    <= '0;
      count     <= '0;
      sum       <= '0;
      sq        <= '0;
      mq_head   <= '0;
      mq_len    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      // Load a new beat, or hold the current one while it is stalled.
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        twrs_pkg::S_IDLE: begin
          if (q_valid && q_item.op == twrs_pkg::OP_CLEAR) begin
            oldest  <= '0;
            count   <= '0;
            sum     <= '0;
            sq      <= '0;
            mq_head <= '0;
            mq_len  <= '0;
          end
        end
        twrs_pkg::S_DROP: begin
          if (do_drop) begin
            sum <= sum - twrs_pkg::SUM_W'(samp_q);
            sq  <= sq - twrs_pkg::SQ_W'(drop_sq);
            if (mq_len != '0 && mq_q == oldest) begin
              mq_head <= idx_add(mq_head, CW'(1));
              mq_len  <= mq_len - CW'(1);
            end
            oldest <= idx_add(oldest, CW'(1));
            count  <= count - CW'(1);
          end
        end
        twrs_pkg::S_WRITE: begin
          count <= count + CW'(1);
          sum   <= sum + twrs_pkg::SUM_W'(cur.dist_cm);
          sq    <= sq + twrs_pkg::SQ_W'(add_sq);
        end
        twrs_pkg::S_MQ_CMP: begin
          if (mq_pop_ok) mq_len <= mq_len - CW'(1);
        end
        twrs_pkg::S_MQ_PUSH: mq_len <= mq_len + CW'(1);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      twrs_pkg::S_IDLE: begin
        cur      <= q_item;
        evicting <= 1'b0;
        acc_flag <= (q_item.op == twrs_pkg::OP_CLEAR) || !reject;
      end
      twrs_pkg::S_WRITE: begin
        slot_r <= slot;
        newest <= cur.ts;
      end
      twrs_pkg::S_MQ_PUSH: evicting <= 1'b1;
      twrs_pkg::S_MAX_GET: begin
        max_r  <= (count != '0 && mq_len != '0) ? clamp : '0;
        mean_r <= '0;
        sd_r   <= '0;
      end
      twrs_pkg::S_PROD: begin
        prod_s2 <= PW'(count) * PW'(sq);
        prod_s1 <= {{twrs_pkg::SUM_W{1'b0}}, sum} * {{twrs_pkg::SUM_W{1'b0}}, sum};
        den     <= den_next;
      end
      twrs_pkg::S_MEAN_WAIT: begin
        if (ds_stat.done) mean_r <= ds_stat.result[twrs_pkg::STAT_W-1:0];
      end
      twrs_pkg::S_SD_WAIT: begin
        if (ds_stat.done) quot_r <= ds_stat.result;
      end
      twrs_pkg::S_ROOT_WAIT: begin
        if (ds_stat.done) begin
          sd_r <= (root[twrs_pkg::ROOT_W-1:twrs_pkg::STAT_W] != '0)
                  ? '1 : root[twrs_pkg::STAT_W-1:0];
        end
      end
      twrs_pkg::S_OUT: begin
        if (out_load) begin
          res.accepted <= acc_flag;
          res.count    <= count;
          res.max_cm   <= max_r;
          res.mean     <= mean_r;
          res.sd       <= sd_r;
          res.sd_valid <= (count >= CW'(2));
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> bench/time_window_range_stats_tb.sv
`timescale 1ns / 1ps

module time_window_range_stats_tb;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int SETTLE_LIMIT = 400;

  // Idle modes, one per phase.
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_SEND   = 1;
  localparam int IDLE_RECV   = 2;
  localparam int IDLE_BOTH   = 3;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [twrs_pkg::ADDR_W-1:0]   paddr;
  logic [twrs_pkg::DATA_W-1:0]   pwdata;
  logic [twrs_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_stall;
  logic                          op;
  logic [twrs_pkg::DIST_W-1:0]   distance_cm;
  logic [twrs_pkg::TIME_W-1:0]   timestamp_ms;
  logic                          out_valid;
  logic                          out_stall;
  logic                          accepted;
  logic [twrs_pkg::CNT_W-1:0]    window_count;
  logic [twrs_pkg::DIST_W-1:0]   window_max_cm;
  logic [twrs_pkg::STAT_W-1:0]   mean_sixteenths;
  logic [twrs_pkg::STAT_W-1:0]   stddev_sixteenths;
  logic                          stddev_valid;

  time_window_range_stats dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .distance_cm(distance_cm), .timestamp_ms(timestamp_ms),
    .out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
    .window_count(window_count), .window_max_cm(window_max_cm),
    .mean_sixteenths(mean_sixteenths), .stddev_sixteenths(stddev_sixteenths),
    .stddev_valid(stddev_valid)
  );

  // Stimulus waiting to go out, and the statistics the block owes us.
  twrs_pkg::item_t   sample_backlog[$];
  twrs_pkg::result_t stats_due[$];
  int                idle_mode;
  int                error_count;
  int                cycle_count;

  // Shadow of the block: registers plus the window contents, oldest first.
  logic [twrs_pkg::DIST_W-1:0] shadow_ceiling;
  logic [twrs_pkg::DIST_W-1:0] shadow_floor;
  logic [twrs_pkg::TIME_W-1:0] shadow_span;
  logic [twrs_pkg::DIST_W-1:0] win_dist[$];
  logic [twrs_pkg::TIME_W-1:0] win_ts[$];

  // Generator state: last timestamp handed out.
  logic [twrs_pkg::TIME_W-1:0] gen_ts;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Bitwise integer square root, floored.
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Summarize the current window into one result beat.
  function automatic twrs_pkg::result_t window_stats(input logic acc);
    twrs_pkg::result_t r;
    longint unsigned   n;
    longint unsigned   s1;
    longint unsigned   s2;
    longint unsigned   peak;
    longint unsigned   sd;
    r = '0;
    n = win_dist.size();
    s1 = 0;
    s2 = 0;
    peak = 0;
    foreach (win_dist[i]) begin
      s1 += win_dist[i];
      s2 += longint'(win_dist[i]) * win_dist[i];
      if (win_dist[i] > peak) peak = win_dist[i];
    end
    r.accepted = acc;
    r.count    = n[twrs_pkg::CNT_W-1:0];
    if (n != 0) begin
      if (peak > shadow_ceiling) peak = shadow_ceiling;
      if (peak < shadow_floor) peak = shadow_floor;
      r.max_cm = peak[twrs_pkg::DIST_W-1:0];
      r.mean   = ((s1 * 16) / n) & 20'hFFFFF;
    end
    if (n >= 2) begin
      sd = int_sqrt(((n * s2 - s1 * s1) * 256) / (n * (n - 1)));
      if (sd > 1048575) sd = 1048575;
      r.sd       = sd[twrs_pkg::STAT_W-1:0];
      r.sd_valid = 1'b1;
    end
    return r;
  endfunction

  // Apply one accepted beat to the shadow window and queue its statistics.
  task automatic apply_sample(input twrs_pkg::item_t it);
    logic keep;
    keep = 1'b1;
    if (it.op == twrs_pkg::OP_CLEAR) begin
      win_dist.delete();
      win_ts.delete();
    end else begin
      // Reject a timestamp that does not move forward.
      if (win_ts.size() != 0 && it.ts <= win_ts[$]) keep = 1'b0;
      if (keep) begin
        if (win_dist.size() >= twrs_pkg::WINDOW_DEPTH) begin
          void'(win_dist.pop_front());
          void'(win_ts.pop_front());
        end
        win_dist.insert(win_dist.size(), it.dist_cm);
        win_ts.insert(win_ts.size(), it.ts);
        // Age out stale samples; the sum is 33 bits wide so it never wraps.
        while (win_ts.size() > 1 &&
               ({1'b0, win_ts[0]} + {1'b0, shadow_span}) < {1'b0, it.ts}) begin
          void'(win_dist.pop_front());
          void'(win_ts.pop_front());
        end
      end
    end
    stats_due.insert(stats_due.size(), window_stats(keep));
  endtask

  function automatic bit sender_rests();
    if (idle_mode == IDLE_SEND) return $urandom_range(99) < 70;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 27;
    return 1'b0;
  endfunction

  // Driver: retire the accepted beat into the shadow, then launch the next.
  always @(posedge clk) begin : drive_beats
    twrs_pkg::item_t nxt;
    twrs_pkg::item_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cur.op      = op;
        cur.dist_cm = distance_cm;
        cur.ts      = timestamp_ms;
        apply_sample(cur);
      end
      if (!in_valid || !in_stall) begin
        if (sample_backlog.size() != 0 && !sender_rests()) begin
          nxt = sample_backlog.pop_front();
          in_valid     <= 1'b1;
          op           <= nxt.op;
          distance_cm  <= nxt.dist_cm;
          timestamp_ms <= nxt.ts;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, want, got);
      error_count++;
    end
  endtask

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk) begin : watch_results
    twrs_pkg::result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (stats_due.size() == 0) begin
          $display("%0t unexpected result beat: expected none actual count %0d",
                   $realtime, window_count);
          error_count++;
        end else begin
          want = stats_due.pop_front();
          check_field("accepted", want.accepted, accepted);
          check_field("window_count", want.count, window_count);
          check_field("window_max_cm", want.max_cm, window_max_cm);
          check_field("mean_sixteenths", want.mean, mean_sixteenths);
          check_field("stddev_sixteenths", want.sd, stddev_sixteenths);
          check_field("stddev_valid", want.sd_valid, stddev_valid);
        end
      end
      // Stall the result side according to the phase.
      if (idle_mode == IDLE_RECV) out_stall <= ($urandom_range(99) < 70);
      else if (idle_mode == IDLE_BOTH) out_stall <= ($urandom_range(99) < 27);
      else out_stall <= 1'b0;
    end
  end

  // Setup cycle, then access cycle; the register takes the value on the access edge.
  task automatic cfg_write(input twrs_pkg::reg_idx_t idx,
                           input logic [twrs_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      twrs_pkg::REG_CEILING: shadow_ceiling = value[twrs_pkg::DIST_W-1:0];
      twrs_pkg::REG_FLOOR:   shadow_floor   = value[twrs_pkg::DIST_W-1:0];
      default:               shadow_span    = value;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] ceil_v, input logic [15:0] floor_v,
                          input logic [31:0] span_v);
    cfg_write(twrs_pkg::REG_CEILING, {16'd0, ceil_v});
    cfg_write(twrs_pkg::REG_FLOOR, {16'd0, floor_v});
    cfg_write(twrs_pkg::REG_SPAN, span_v);
  endtask

  task automatic add_item(input logic o, input logic [15:0] d, input logic [31:0] t);
    twrs_pkg::item_t it;
    it.op      = o;
    it.dist_cm = d;
    it.ts      = t;
    sample_backlog.insert(sample_backlog.size(), it);
  endtask

  // Hold until every beat is out and every result is in, then let the block settle.
  task automatic drain();
    while (sample_backlog.size() != 0 || in_valid || stats_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_LIMIT) @(posedge clk);
  endtask

  // Mostly forward-moving timestamps; a few repeats, steps back and clears.
  task automatic random_burst(input int count, input int step_max, input int clear_pct,
                              input int reject_pct);
    int          roll;
    logic [15:0] d;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      d = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(300, 2500));
      if (roll < clear_pct || gen_ts > 32'hF000_0000) begin
        add_item(twrs_pkg::OP_CLEAR, 16'($urandom), $urandom);
        // Restart the clock anywhere, so the high bits get exercised too.
        gen_ts = ($urandom_range(1) == 0) ? $urandom_range(1000) : ($urandom >> 1);
      end else if (roll < clear_pct + reject_pct) begin
        add_item(twrs_pkg::OP_ADD, d,
                 gen_ts - $urandom_range(0, (gen_ts < 3) ? gen_ts : 3));
      end else begin
        gen_ts = gen_ts + $urandom_range(1, step_max);
        add_item(twrs_pkg::OP_ADD, d, gen_ts);
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    op          = twrs_pkg::OP_ADD;
    distance_cm = '0;
    timestamp_ms = '0;
    out_stall   = 1'b0;
    idle_mode   = IDLE_NONE;
    error_count = 0;
    cycle_count = 0;
    gen_ts      = '0;
    // Reset defaults of the registers.
    shadow_ceiling = 16'd2000;
    shadow_floor   = 16'd500;
    shadow_span    = 32'd4000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: clear on empty, extremes, rejects, eviction, ceiling and floor.
    add_item(twrs_pkg::OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    add_item(twrs_pkg::OP_ADD, 16'd0, 32'd0);
    add_item(twrs_pkg::OP_ADD, 16'hFFFF, 32'd10);
    add_item(twrs_pkg::OP_ADD, 16'd700, 32'd10);
    add_item(twrs_pkg::OP_ADD, 16'd700, 32'd5);
    add_item(twrs_pkg::OP_ADD, 16'd100, 32'd20);
    add_item(twrs_pkg::OP_ADD, 16'd1200, 32'd4020);
    add_item(twrs_pkg::OP_ADD, 16'd1300, 32'd4021);
    add_item(twrs_pkg::OP_ADD, 16'd50, 32'd9000);
    add_item(twrs_pkg::OP_CLEAR, 16'h5A5A, 32'h1234_5678);
    add_item(twrs_pkg::OP_ADD, 16'd600, 32'd0);
    add_item(twrs_pkg::OP_ADD, 16'd600, 32'd1);
    add_item(twrs_pkg::OP_ADD, 16'hFFFF, 32'd2);
    drain();

    // Widest span and timestamps at the top of the range.
    set_regs(16'hFFFF, 16'd0, 32'hFFFF_FFFF);
    add_item(twrs_pkg::OP_ADD, 16'hFFFF, 32'hFFFF_FFF0);
    add_item(twrs_pkg::OP_ADD, 16'hFFFF, 32'hFFFF_FFFE);
    add_item(twrs_pkg::OP_ADD, 16'd0, 32'hFFFF_FFFF);
    add_item(twrs_pkg::OP_ADD, 16'd1, 32'hFFFF_FFFF);
    add_item(twrs_pkg::OP_CLEAR, 16'd0, 32'd0);
    drain();

    // Fill past the window depth with no clears: oldest beat drops out.
    idle_mode = IDLE_SEND;
    gen_ts = 32'd100;
    random_burst(300, 50, 0, 3);
    drain();

    // Floor above ceiling, zero span: the window holds only the newest sample.
    set_regs(16'd300, 16'd800, 32'd0);
    idle_mode = IDLE_RECV;
    random_burst(100, 20, 4, 10);
    drain();

    // Moderate span with stalls on both sides; also hold the sender here.
    set_regs(16'd40000, 16'd1000, 32'd500);
    idle_mode = IDLE_BOTH;
    random_burst(200, 100, 3, 8);
    drain();

    // Back to the default settings with no idling.
    set_regs(16'd2000, 16'd500, 32'd4000);
    idle_mode = IDLE_NONE;
    random_burst(150, 1000, 3, 8);
    drain();

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
